// ===== rtl/core/cht_pkg.sv =====
// shared types and constants for the chained hash table
// no dependencies; used by chained_hash_table_insert_lookup
`default_nettype none

package cht_pkg;

   // default sizes of the table
   localparam int NUM_BUCKETS_DEF  = 8;
   localparam int BUCKET_DEPTH_DEF = 8;
   localparam int KEY_WIDTH_DEF    = 31;

   // fixed widths of the channel fields
   localparam int KEY_FIELD_W    = 31;
   localparam int INDEX_FIELD_W  = 3;

   // operation codes
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef struct packed {
      logic                   kind;
      logic [KEY_FIELD_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic [INDEX_FIELD_W-1:0] bucket_index;
      logic [INDEX_FIELD_W-1:0] slot_index;
      logic                     bucket_full;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/cht_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/chained_hash_table_insert_lookup.sv =====
// chained hash table: insert and lookup of keys in fixed-size buckets
// depends on cht_pkg and cht_ram
//
// usage
//   req channel carries one operation (insert or lookup) and a key; rsp channel
//   returns exactly one result per request, in order. both channels transfer
//   on a clock edge with valid high and stall low.
//   the bucket is key modulo NUM_BUCKETS. for a power-of-two bucket count it
//   is a bit select; otherwise a shared subtract unit reduces the key four
//   bits a cycle.
//   after the request transfer the fill count is read and checked, and the
//   result is then registered; an insert goes from fill read to fill check
//   to the result step, and back to idle once its result is registered.
//   a lookup compares one stored key per cycle through the key ram read
//   port, scanning at most BUCKET_DEPTH slots and stopping at the first
//   match or at the bucket's fill count; an empty bucket is not scanned.
//   one request is in flight at a time: req_stall is high from the request
//   transfer until its result sits in the output register.
//   a stalled result holds in the output register; the sequencer waits in
//   its result step until the register frees up.
//   synchronous reset empties every bucket at once through per-bucket valid
//   bits; stored keys are not cleared and are never read before written.
`default_nettype none

module chained_hash_table_insert_lookup #(
   parameter int NUM_BUCKETS  = cht_pkg::NUM_BUCKETS_DEF,
   parameter int BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF,
   parameter int KEY_WIDTH    = cht_pkg::KEY_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire cht_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output cht_pkg::rsp_type      rsp_data
);

   localparam int KW    = (KEY_WIDTH < cht_pkg::KEY_FIELD_W) ? KEY_WIDTH
                                                             : cht_pkg::KEY_FIELD_W;
   localparam int BW    = $clog2(NUM_BUCKETS);
   localparam int SLW   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
   localparam int FW    = $clog2(BUCKET_DEPTH + 1);
   localparam int ENTRIES = NUM_BUCKETS * BUCKET_DEPTH;
   localparam int AW    = $clog2(ENTRIES);
   localparam bit POW2  = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;
   localparam int DIGIT = 4;
   localparam int STEPS = (KW + DIGIT - 1) / DIGIT;
   localparam int PW    = STEPS * DIGIT;
   localparam int CW    = $clog2(STEPS + 1);
   localparam int IW    = cht_pkg::INDEX_FIELD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_FILL_RD,
      ST_FILL_CHK,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type          state_ff, state_in;
   logic               kind_ff, kind_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [PW-1:0]      shift_ff, shift_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [BW-1:0]      bucket_ff, bucket_in;
   logic [AW-1:0]      base_ff, base_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [SLW-1:0]     slot_ff, slot_in;
   logic               found_ff, found_in;
   logic               full_ff, full_in;
   logic [NUM_BUCKETS-1:0] fill_vld_ff, fill_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cht_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // ram ports
   logic               key_wr_en, key_rd_en;
   logic [AW-1:0]      key_wr_addr, key_rd_addr;
   logic [KW-1:0]      key_rd_data;
   logic               fill_wr_en, fill_rd_en;
   logic [FW-1:0]      fill_wr_data, fill_rd_data;

   logic [FW-1:0]      fill_cur;
   logic [BW:0]        rem_t;
   logic [BW+IW-1:0]   bucket_ext;
   logic [SLW+IW-1:0]  slot_ext;

   cht_ram #(
      .WIDTH (KW),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_ff),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   cht_ram #(
      .WIDTH (FW),
      .DEPTH (NUM_BUCKETS)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_wr_en),
      .wr_addr (bucket_ff),
      .wr_data (fill_wr_data),
      .rd_en   (fill_rd_en),
      .rd_addr (bucket_ff),
      .rd_data (fill_rd_data)
   );

   // a bucket never written since reset counts as empty
   assign fill_cur   = fill_vld_ff[bucket_ff] ? fill_rd_data : '0;
   assign bucket_ext = {{IW{1'b0}}, bucket_ff};
   assign slot_ext   = {{IW{1'b0}}, slot_ff};

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      shift_in     = shift_ff;
      step_in      = step_ff;
      bucket_in    = bucket_ff;
      base_in      = base_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      full_in      = full_ff;
      fill_vld_in  = fill_vld_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      key_wr_en    = 1'b0;
      key_wr_addr  = base_ff + AW'(fill_cur);
      key_rd_en    = 1'b0;
      key_rd_addr  = base_ff;
      fill_wr_en   = 1'b0;
      fill_wr_data = fill_cur + FW'(1);
      fill_rd_en   = 1'b0;
      rem_t        = {1'b0, bucket_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_data.kind;
               key_in  = req_data.key[KW-1:0];
               if (POW2) begin
                  bucket_in = req_data.key[BW-1:0];
                  state_in  = ST_FILL_RD;
               end else begin
                  bucket_in = '0;
                  shift_in  = PW'(req_data.key[KW-1:0]);
                  step_in   = '0;
                  state_in  = ST_HASH;
               end
            end
         end

         ST_HASH: begin
            // restoring remainder, one key bit per inner step, msb first
            for (int i = 0; i < DIGIT; i++) begin
               rem_t = {rem_t[BW-1:0], shift_ff[PW-1-i]};
               if (rem_t >= (BW+1)'(NUM_BUCKETS)) begin
                  rem_t = rem_t - (BW+1)'(NUM_BUCKETS);
               end
            end
            bucket_in = rem_t[BW-1:0];
            shift_in  = shift_ff << DIGIT;
            step_in   = step_ff + CW'(1);
            if (step_ff == CW'(STEPS - 1)) begin
               state_in = ST_FILL_RD;
            end
         end

         ST_FILL_RD: begin
            fill_rd_en = 1'b1;
            base_in    = AW'(bucket_ff * BUCKET_DEPTH);
            state_in   = ST_FILL_CHK;
         end

         ST_FILL_CHK: begin
            fill_in  = fill_cur;
            found_in = 1'b0;
            full_in  = 1'b0;
            slot_in  = '0;
            if (kind_ff == cht_pkg::KIND_INSERT) begin
               if (fill_cur < FW'(BUCKET_DEPTH)) begin
                  key_wr_en   = 1'b1;
                  fill_wr_en  = 1'b1;
                  fill_vld_in[bucket_ff] = 1'b1;
                  found_in    = 1'b1;
                  slot_in     = SLW'(fill_cur);
               end else begin
                  full_in = 1'b1;
               end
               state_in = ST_RESULT;
            end else if (fill_cur == '0) begin
               state_in = ST_RESULT;
            end else begin
               key_rd_en = 1'b1;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // read data belongs to slot_ff; next slot is fetched alongside
            if (key_rd_data == key_ff) begin
               found_in = 1'b1;
               state_in = ST_RESULT;
            end else if (FW'(slot_ff) + FW'(1) == fill_ff) begin
               slot_in  = '0;
               state_in = ST_RESULT;
            end else begin
               slot_in     = slot_ff + SLW'(1);
               key_rd_en   = 1'b1;
               key_rd_addr = base_ff + AW'(slot_ff) + AW'(1);
            end
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.found        = found_ff;
               rsp_data_in.bucket_index = bucket_ext[IW-1:0];
               rsp_data_in.slot_index   = slot_ext[IW-1:0];
               rsp_data_in.bucket_full  = full_ff;
               state_in                 = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_vld_ff  <= fill_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      shift_ff    <= shift_in;
      step_ff     <= step_in;
      bucket_ff   <= bucket_in;
      base_ff     <= base_in;
      fill_ff     <= fill_in;
      slot_ff     <= slot_in;
      found_ff    <= found_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
